[src/neuron_dot_product_softsign_defines.svh]
// Assertion macros shared by the checker of the neuron block.
// No dependencies; included by files that assert.
`ifndef NEURON_DOT_PRODUCT_SOFTSIGN_DEFINES_SVH
`define NEURON_DOT_PRODUCT_SOFTSIGN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define NDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define NDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define NDS_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/nds_pkg.sv]
// Package for the neuron block: sizes, number formats, FSM and status types.
// No dependencies.
package nds_pkg;

    localparam int MAX_INPUTS = 64;
    localparam int DATA_W     = 16;
    localparam int FRAC_IN    = DATA_W - 4;
    localparam int OUT_FRAC   = DATA_W - 1;
    localparam int ACC_W      = 40;
    localparam int DEPTH      = MAX_INPUTS + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(OUT_FRAC + 1);
    localparam int REM_W      = ACC_W + 1;
    localparam int PROD_W     = 2 * DATA_W;

    // Operation codes on the request channel
    localparam logic OP_WEIGHT  = 1'b0;
    localparam logic OP_ELEMENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_MAC,
        ST_ACC,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Count register clamped to 1 .. MAX_INPUTS
    function automatic logic [ADDR_W-1:0] eff_count(input logic [ADDR_W-1:0] cnt);
        logic [ADDR_W-1:0] res;
        if (cnt == '0) begin
            res = ADDR_W'(1);
        end else if (cnt > ADDR_W'(MAX_INPUTS)) begin
            res = ADDR_W'(MAX_INPUTS);
        end else begin
            res = cnt;
        end
        return res;
    endfunction

endpackage

[src/nds_wmem.sv]
// Weight table: one write port, one read port with registered data.
// Depends on nds_pkg.
module nds_wmem import nds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/nds_softsign.sv]
// Softsign unit: restoring divide of |acc| by (1 + |acc|), one bit per cycle.
// Depends on nds_pkg.
module nds_softsign import nds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_acc,
    output t_div_stat         o_stat,
    output logic [DATA_W-1:0] o_result
);

    logic [REM_W-1:0]    r_rem, n_rem;
    logic [REM_W-1:0]    r_den;
    logic [OUT_FRAC-1:0] r_q;
    logic                r_neg;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy, r_done;

    logic [ACC_W-1:0]    mag;
    logic [REM_W:0]      shifted, diff;
    logic                ge;
    logic [DATA_W-1:0]   q_ext;

    // magnitude of the start operand
    assign mag = i_acc[ACC_W-1] ? (~i_acc + 1'b1) : i_acc;

    // one restoring step
    always_comb begin
        shifted = {r_rem, 1'b0};
        diff    = shifted - {1'b0, r_den};
        ge      = shifted >= {1'b0, r_den};
        n_rem   = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    end

    // control: busy and a done pulse after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(OUT_FRAC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_acc[ACC_W-1];
            r_rem <= {1'b0, mag};
            r_den <= {1'b0, mag} + (REM_W'(1) << (2 * FRAC_IN));
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[OUT_FRAC-2:0], ge};
        end
    end

    // sign applied after truncation
    assign q_ext    = {1'b0, r_q};
    assign o_result = r_neg ? (~q_ext + 1'b1) : q_ext;
    assign o_stat   = '{busy: r_busy, done: r_done};

endmodule

[src/neuron_dot_product_softsign.sv]
// Top level of the neuron: request sequencer, MAC datapath, output register.
// Depends on nds_pkg, nds_wmem, nds_softsign.
//
//  channel   handshake                      payload
//  request   i_in_valid / o_in_ready        i_op, i_index, i_value
//  result    o_out_valid / i_out_ready      o_activation
//  config    i_cfg_wr_en                    i_cfg_wr_data
//
// Weight write: stays in ST_IDLE. Element: ST_MAC, then ST_ACC; ST_BIAS comes first for
// the first of an evaluation (the single read port of the weight table fetches the bias
// first). Last element adds start, 15 divide steps (one quotient bit each), done, load.
// Synchronous reset clears control state and the accumulator, not the weight table.
// A stalled result holds in the output register; requests are taken meanwhile, and the
// next result waits in ST_OUT, taking no requests, until the register frees up.
module neuron_dot_product_softsign import nds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [ADDR_W-1:0] i_index,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_activation,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_wr_data
);

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_count;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [DATA_W-1:0]  r_val;
    logic [PROD_W-1:0]  r_prod;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_act;

    logic [ADDR_W-1:0]  cnt_eff;
    logic [ADDR_W-1:0]  pos_eff;
    logic [ADDR_W-1:0]  pos_inc;
    logic               accept;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;
    logic               div_start;
    t_div_stat          div_stat;
    logic [DATA_W-1:0]  div_result;
    logic               out_load;

    assign cnt_eff = eff_count(r_count);
    assign pos_eff = (r_pos >= cnt_eff) ? '0 : r_pos;
    assign pos_inc = r_pos + 1'b1;
    assign accept  = i_in_valid && o_in_ready;
    assign mem_we  = accept && (i_op == OP_WEIGHT) && (i_index <= ADDR_W'(MAX_INPUTS));

    nds_wmem u_wmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_index),
        .i_wdata (i_value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    nds_softsign u_softsign (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_acc    (r_acc),
        .o_stat   (div_stat),
        .o_result (div_result)
    );

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= ADDR_W'(1);
            r_pos       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
                r_pos   <= '0;
                r_acc   <= '0;
            end else begin
                r_pos <= n_pos;
                r_acc <= n_acc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val <= i_value;
        end
        if (r_state == ST_MAC) begin
            r_prod <= PROD_W'($signed(r_val) * $signed(mem_rdata));
        end
        if (out_load) begin
            r_act <= div_result;
        end
    end

    // next state, memory address, accumulator update
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_acc       = r_acc;
        mem_raddr   = r_pos;
        div_start   = 1'b0;
        out_load    = 1'b0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                mem_raddr  = (pos_eff == '0) ? cnt_eff : pos_eff;
                if (i_in_valid && (i_op == OP_ELEMENT)) begin
                    n_pos   = pos_eff;
                    n_state = (pos_eff == '0) ? ST_BIAS : ST_MAC;
                end
            end
            ST_BIAS: begin
                // bias aligned to the product format
                n_acc     = {{(ACC_W - DATA_W - FRAC_IN){mem_rdata[DATA_W-1]}},
                             mem_rdata, {FRAC_IN{1'b0}}};
                mem_raddr = r_pos;
                n_state   = ST_MAC;
            end
            ST_MAC: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_acc = r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
                if (pos_inc < cnt_eff) begin
                    n_pos   = pos_inc;
                    n_state = ST_IDLE;
                end else begin
                    n_pos   = '0;
                    n_state = ST_DSTART;
                end
            end
            ST_DSTART: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_acc       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_activation = r_act;

endmodule

[src/nds_checker.sv]
// Port-level checks for the neuron block, bound to the top level.
// Depends on neuron_dot_product_softsign_defines.svh.
`include "neuron_dot_product_softsign_defines.svh"

module nds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_op,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_activation
);

    // a stalled result stays up
    `NDS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // softsign magnitude stays below one, so the most negative code never shows
    `NDS_ASSERT_NOW(a_act_range, o_out_valid, o_activation != 16'h8000)

    // reset leaves the block ready with no pending result
    `NDS_ASSERT_RST(a_reset_state, !i_rst_n, o_in_ready && !o_out_valid)

    // a weight write produces no result
    `NDS_ASSERT_NEXT(a_wr_no_result, i_in_valid && o_in_ready && !i_op && !o_out_valid,
                     !o_out_valid)

    // an element request occupies the datapath for the following cycle
    `NDS_ASSERT_NEXT(a_elem_busy, i_in_valid && o_in_ready && i_op, !o_in_ready)

endmodule

bind neuron_dot_product_softsign nds_checker u_nds_checker (.*);
